// ===== rtl/core/srlm_pkg.sv =====
package srlm_pkg;
    localparam int COL_W = 10;
    localparam int VAL_W = 64;
    localparam int CNT_W = 16;

    localparam logic [1:0] FN_READ     = 2'd0;
    localparam logic [1:0] FN_PUT      = 2'd1;
    localparam logic [1:0] FN_ASSEMBLE = 2'd2;
    localparam logic [1:0] FN_CLEAR    = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic load;      // capture the item and the row length
        logic rd_slot;   // issue a slot read at the scan pointer
        logic rd_prev;   // issue a slot read one below the pointer
        logic adv;       // step the scan pointer up
        logic mark_pos;  // keep the insert position, move pointer to the row end
        logic shift;     // write the slot read below into the pointer, step down
        logic wr_new;    // write the new entry at the pointer
        logic wr_upd;    // overwrite or accumulate the found entry
        logic hit;       // take the read value as the result
        logic set_full;  // flag a refused insert
        logic clr_row;   // zero the row length
        logic init_step; // clear one row length after reset
        logic done;      // present the result
    } t_cmd;

    typedef struct packed {
        logic row_ok;
        logic col_ok;
        logic is_clear;
        logic is_read;
        logic scan_end;  // pointer reached the row length
        logic col_ge;    // column at pointer is >= requested column
        logic col_eq;
        logic row_full;
        logic at_pos;    // shift pointer reached the insert position
        logic init_last; // last row length of the clearing pass
    } t_sts;
endpackage

// ===== rtl/core/srlm_ctrl.sv =====
module srlm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  srlm_pkg::t_sts i_sts,
    output srlm_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_SHF  = 3'd4;
    localparam logic [2:0] S_SHW  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;
    localparam logic [2:0] S_INIT = 3'd7;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_go) begin
                    o_cmd.load = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!i_sts.row_ok) begin
                    n_state = S_DONE;
                end else if (i_sts.is_clear) begin
                    o_cmd.clr_row = 1'b1;
                    n_state = S_DONE;
                end else if (!i_sts.col_ok) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.scan_end) begin
                    // not found: append at the end of the row
                    if (i_sts.row_full) o_cmd.set_full = !i_sts.is_read;
                    else o_cmd.wr_new = !i_sts.is_read;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_slot = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_sts.col_ge) begin
                    o_cmd.adv = 1'b1;
                    n_state = S_RD;
                end else if (i_sts.col_eq) begin
                    if (i_sts.is_read) o_cmd.hit = 1'b1;
                    else o_cmd.wr_upd = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.is_read) begin
                    n_state = S_DONE;
                end else if (i_sts.row_full) begin
                    o_cmd.set_full = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.mark_pos = 1'b1;
                    n_state = S_SHF;
                end
            end
            S_SHF: begin
                if (i_sts.at_pos) begin
                    o_cmd.wr_new = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state = S_SHW;
                end
            end
            S_SHW: begin
                o_cmd.shift = 1'b1;
                n_state = S_SHF;
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ===== rtl/core/srlm_dp.sv =====
module srlm_dp #(
    parameter int ROWS      = 1024,
    parameter int ROW_SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srlm_pkg::t_cmd                i_cmd,
    input  logic [1:0]                    i_func,
    input  logic [9:0]                    i_row_index,
    input  logic [9:0]                    i_col_index,
    input  logic signed [63:0]            i_entry_value,
    output srlm_pkg::t_sts                o_sts,
    output logic                          o_done,
    output logic signed [63:0]            o_read_value,
    output logic [1:0]                    o_status,
    output logic [15:0]                   o_nonzero_total
);
    localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW  = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
    localparam int LW  = $clog2(ROW_SLOTS + 1);
    localparam int AW  = RW + SW;
    localparam int DEP = ROWS * (2 ** SW);

    logic [srlm_pkg::COL_W-1:0] m_col [DEP];
    logic [srlm_pkg::VAL_W-1:0] m_val [DEP];
    logic [LW-1:0]              r_len [ROWS];

    logic [1:0]  r_func;
    logic [9:0]  r_row, r_colq;
    logic [srlm_pkg::VAL_W-1:0] r_val;
    logic        r_row_ok, r_col_ok;
    logic [LW-1:0] r_rlen, r_ptr, r_pos;
    logic [srlm_pkg::COL_W-1:0] r_rd_col;
    logic [srlm_pkg::VAL_W-1:0] r_rd_val;
    logic [srlm_pkg::CNT_W-1:0] r_cnt;
    logic        r_done;
    logic [srlm_pkg::VAL_W-1:0] r_res;
    logic [1:0]  r_st;
    logic [RW-1:0] r_iptr;

    logic [RW-1:0] row_a, len_addr;
    logic [AW-1:0] a_ptr, a_prev, rd_addr;
    logic [63:0]   sum, sat_val, upd_val, wr_val;
    logic [srlm_pkg::COL_W-1:0] wr_col;
    logic [LW-1:0] len_wdata;
    logic          ovf, full, mem_we, len_we;

    assign row_a   = RW'(r_row);
    assign a_ptr   = {row_a, r_ptr[SW-1:0]};
    assign a_prev  = {row_a, SW'(r_ptr - LW'(1))};
    assign rd_addr = i_cmd.rd_prev ? a_prev : a_ptr;
    assign full    = (r_rlen >= LW'(ROW_SLOTS));
    assign sum     = r_rd_val + r_val;
    assign ovf     = (r_rd_val[63] == r_val[63]) && (sum[63] != r_rd_val[63]);
    assign sat_val = r_rd_val[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    assign upd_val = (r_func == srlm_pkg::FN_PUT) ? r_val : (ovf ? sat_val : sum);
    assign mem_we  = i_cmd.shift || i_cmd.wr_new || i_cmd.wr_upd;

    always_comb begin
        wr_col = r_colq;
        wr_val = r_val;
        if (i_cmd.shift) begin
            wr_col = r_rd_col;
            wr_val = r_rd_val;
        end else if (i_cmd.wr_upd) begin
            wr_val = upd_val;
        end
    end

    always_comb begin
        o_sts.row_ok    = r_row_ok;
        o_sts.col_ok    = r_col_ok;
        o_sts.is_clear  = (r_func == srlm_pkg::FN_CLEAR);
        o_sts.is_read   = (r_func == srlm_pkg::FN_READ);
        o_sts.scan_end  = (r_ptr >= r_rlen);
        o_sts.col_ge    = (r_rd_col >= r_colq);
        o_sts.col_eq    = (r_rd_col == r_colq);
        o_sts.row_full  = full;
        o_sts.at_pos    = (r_ptr == r_pos);
        o_sts.init_last = (r_iptr == RW'(ROWS - 1));
    end

    // slot store: one read and one write address per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_slot || i_cmd.rd_prev) begin
            r_rd_col <= m_col[rd_addr];
            r_rd_val <= m_val[rd_addr];
        end
        if (mem_we) begin
            m_col[a_ptr] <= wr_col;
            m_val[a_ptr] <= wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_row    <= i_row_index;
            r_colq   <= i_col_index;
            r_val    <= i_entry_value;
            r_row_ok <= (32'(i_row_index) < ROWS);
            r_col_ok <= (32'(i_col_index) < ROWS);
            r_ptr    <= '0;
            r_res    <= '0;
            r_st     <= srlm_pkg::ST_OK;
        end
        if (i_cmd.adv) r_ptr <= r_ptr + LW'(1);
        if (i_cmd.mark_pos) begin
            // shift walks down from the row end to the insert position
            r_pos <= r_ptr;
            r_ptr <= r_rlen;
        end
        if (i_cmd.shift) r_ptr <= r_ptr - LW'(1);
        if (i_cmd.wr_new) r_res <= r_val;
        if (i_cmd.wr_upd) begin
            r_res <= upd_val;
            if (r_func != srlm_pkg::FN_PUT && ovf) r_st <= srlm_pkg::ST_SAT;
        end
        if (i_cmd.hit) r_res <= r_rd_val;
        if (i_cmd.set_full) r_st <= srlm_pkg::ST_FULL;
    end

    // row length table: cleared by a pass after reset
    assign len_we    = i_cmd.init_step || i_cmd.clr_row || i_cmd.wr_new;
    assign len_addr  = i_cmd.init_step ? r_iptr : row_a;
    assign len_wdata = i_cmd.wr_new ? r_rlen + LW'(1) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_rlen <= r_len[RW'(i_row_index)];
        if (len_we) r_len[len_addr] <= len_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
            r_iptr <= '0;
        end else begin
            r_done <= i_cmd.done;
            if (i_cmd.init_step) r_iptr <= r_iptr + RW'(1);
            if (i_cmd.clr_row) r_cnt <= r_cnt - 16'(r_rlen);
            if (i_cmd.wr_new) r_cnt <= r_cnt + 16'd1;
        end
    end

    assign o_done          = r_done;
    assign o_read_value    = r_res;
    assign o_status        = r_st;
    assign o_nonzero_total = r_cnt;
endmodule

// ===== rtl/core/sparse_row_list_matrix_store.sv =====
// Throughput: one item at a time; busy drops in the o_done cycle.
// Reset (synchronous, i_rst_n low) zeroes the count, then a pass with busy high
// clears the row lengths. The receiver cannot stall.
module sparse_row_list_matrix_store #(
    parameter int ROWS      = 1024,
    parameter int ROW_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [9:0]         i_row_index,
    input  logic [9:0]         i_col_index,
    input  logic signed [63:0] i_entry_value,
    output logic               o_done,
    output logic signed [63:0] o_read_value,
    output logic [1:0]         o_status,
    output logic [15:0]        o_nonzero_total
);
    srlm_pkg::t_cmd cmd;
    srlm_pkg::t_sts sts;

    srlm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(start),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    srlm_dp #(.ROWS(ROWS), .ROW_SLOTS(ROW_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_func(i_func), .i_row_index(i_row_index), .i_col_index(i_col_index),
        .i_entry_value(i_entry_value), .o_sts(sts), .o_done(o_done),
        .o_read_value(o_read_value), .o_status(o_status),
        .o_nonzero_total(o_nonzero_total)
    );
endmodule

// ===== rtl/core/srlm_chk.sv =====
module srlm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [15:0] o_nonzero_total
);
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_status != 2'd3) else $error("bad status");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !o_done |=> $stable(o_nonzero_total) || o_done)
        else $error("count moved while idle");
endmodule

bind sparse_row_list_matrix_store srlm_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_status(o_status), .o_nonzero_total(o_nonzero_total)
);

// ===== test/tb_sparse_row_list_matrix_store.sv =====
module tb_sparse_row_list_matrix_store;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS = 1024;
    localparam int SLOTS = 32;
    localparam int STALL_LIMIT = 20000;
    localparam logic signed [63:0] POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] NEG_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         status;
        logic [15:0]        total;
    } t_outcome;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_func;
    logic [9:0]         i_row_index;
    logic [9:0]         i_col_index;
    logic signed [63:0] i_entry_value;
    logic               o_done;
    logic signed [63:0] o_read_value;
    logic [1:0]         o_status;
    logic [15:0]        o_nonzero_total;

    // shadow of the matrix: per row, sorted column list and values
    logic [9:0]         row_cols [NROWS][SLOTS];
    logic signed [63:0] row_vals [NROWS][SLOTS];
    int                 row_len  [NROWS];
    logic [15:0]        entry_count;

    t_outcome pending_outcomes[$];
    int       error_count;
    int       idle_cycles;
    int       send_gap_pct;

    sparse_row_list_matrix_store u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .i_entry_value  (i_entry_value),
        .o_done         (o_done),
        .o_read_value   (o_read_value),
        .o_status       (o_status),
        .o_nonzero_total(o_nonzero_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_outcome apply_operation(logic [1:0] func, logic [9:0] row,
                                                 logic [9:0] col, logic signed [63:0] val);
        t_outcome o;
        int pos;
        int len;
        logic signed [63:0] sum;
        o = '{value: 64'sd0, status: srlm_pkg::ST_OK, total: 16'd0};
        if (row < NROWS) begin
            len = row_len[row];
            if (func == srlm_pkg::FN_CLEAR) begin
                entry_count = entry_count - 16'(len);
                row_len[row] = 0;
            end else if (col < NROWS) begin
                pos = 0;
                while (pos < len && row_cols[row][pos] < col) pos++;
                if (pos < len && row_cols[row][pos] == col) begin
                    if (func == srlm_pkg::FN_PUT) begin
                        row_vals[row][pos] = val;
                    end else if (func == srlm_pkg::FN_ASSEMBLE) begin
                        sum = row_vals[row][pos] + val;
                        if (row_vals[row][pos][63] == val[63] && sum[63] != val[63]) begin
                            sum = val[63] ? NEG_MIN : POS_MAX;
                            o.status = srlm_pkg::ST_SAT;
                        end
                        row_vals[row][pos] = sum;
                    end
                    o.value = row_vals[row][pos];
                end else if (func != srlm_pkg::FN_READ) begin
                    if (len >= SLOTS) begin
                        o.status = srlm_pkg::ST_FULL;
                    end else begin
                        for (int k = len; k > pos; k--) begin
                            row_cols[row][k] = row_cols[row][k-1];
                            row_vals[row][k] = row_vals[row][k-1];
                        end
                        row_cols[row][pos] = col;
                        row_vals[row][pos] = val;
                        row_len[row] = len + 1;
                        entry_count = entry_count + 16'd1;
                        o.value = val;
                    end
                end
            end
        end
        o.total = entry_count;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // sample results and count quiet cycles for the watchdog
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if ((start && !busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_done) begin
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", o_read_value, 64'd0);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (o_read_value !== want.value)
                        report_mismatch("read_value", o_read_value, want.value);
                    if (o_status !== want.status)
                        report_mismatch("status", 64'(o_status), 64'(want.status));
                    if (o_nonzero_total !== want.total)
                        report_mismatch("nonzero_total", 64'(o_nonzero_total),
                                        64'(want.total));
                end
            end
        end
    end

    initial begin
        @(posedge i_clk);
        wait (idle_cycles >= STALL_LIMIT);
        $display("[sparse_row_list_matrix_store] ERROR");
        $finish;
    end

    task automatic send_item(logic [1:0] func, logic [9:0] row, logic [9:0] col,
                             logic signed [63:0] val);
        @(posedge i_clk);
        while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        start         <= 1'b1;
        i_func        <= func;
        i_row_index   <= row;
        i_col_index   <= col;
        i_entry_value <= val;
        do @(posedge i_clk); while (busy);
        pending_outcomes.insert(pending_outcomes.size(), apply_operation(func, row, col, val));
        start         <= 1'b0;
        i_func        <= 2'($urandom);
        i_row_index   <= 10'($urandom);
        i_col_index   <= 10'($urandom);
        i_entry_value <= {$urandom, $urandom};
    endtask

    task automatic drain_results();
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [63:0] random_value();
        case ($urandom_range(5))
            0: return POS_MAX - 64'($urandom_range(3));
            1: return NEG_MIN + 64'($urandom_range(3));
            2: return 64'sd0;
            3: return 64'(signed'($urandom_range(200)) - 100) <<< 32;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_directed();
        send_item(srlm_pkg::FN_READ, 10'd0, 10'd0, 64'sd0);
        send_item(srlm_pkg::FN_PUT, 10'd0, 10'd1023, POS_MAX);
        send_item(srlm_pkg::FN_PUT, 10'd0, 10'd0, NEG_MIN);
        send_item(srlm_pkg::FN_PUT, 10'd0, 10'd500, 64'sd0);
        send_item(srlm_pkg::FN_READ, 10'd0, 10'd1023, 64'sd0);
        send_item(srlm_pkg::FN_READ, 10'd0, 10'd500, 64'sd0);
        send_item(srlm_pkg::FN_ASSEMBLE, 10'd0, 10'd1023, 64'sd1);
        send_item(srlm_pkg::FN_ASSEMBLE, 10'd0, 10'd0, -64'sd1);
        send_item(srlm_pkg::FN_ASSEMBLE, 10'd0, 10'd500, 64'sh0000_0001_8000_0000);
        send_item(srlm_pkg::FN_PUT, 10'd0, 10'd500, -64'sd5);
        send_item(srlm_pkg::FN_ASSEMBLE, 10'd1023, 10'd7, 64'sh5555_5555_AAAA_AAAA);
        send_item(srlm_pkg::FN_READ, 10'd1023, 10'd7, 64'sd0);
        send_item(srlm_pkg::FN_CLEAR, 10'd0, 10'd9, 64'sd0);
        send_item(srlm_pkg::FN_READ, 10'd0, 10'd0, 64'sd0);
        send_item(srlm_pkg::FN_CLEAR, 10'd1023, 10'd0, 64'sd0);
        send_item(srlm_pkg::FN_CLEAR, 10'd2, 10'd0, 64'sd0);
        // fill one row past its capacity, out of order
        for (int i = 0; i < SLOTS + 2; i++)
            send_item(i[0] ? srlm_pkg::FN_PUT : srlm_pkg::FN_ASSEMBLE, 10'd5,
                      10'((i * 37) % 1024), 64'(i) <<< 32);
        send_item(srlm_pkg::FN_ASSEMBLE, 10'd5, 10'd0, 64'sd3);
        send_item(srlm_pkg::FN_READ, 10'd5, 10'd37, 64'sd0);
        drain_results();
    endtask

    task automatic test_random(int count);
        logic [1:0] func;
        logic [9:0] row;
        for (int n = 0; n < count; n++) begin
            // a few hot rows fill up; others stay sparse
            row = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(7));
            case ($urandom_range(19))
                0:       func = srlm_pkg::FN_CLEAR;
                1, 2, 3, 4, 5, 6: func = srlm_pkg::FN_READ;
                7, 8, 9, 10, 11: func = srlm_pkg::FN_PUT;
                default: func = srlm_pkg::FN_ASSEMBLE;
            endcase
            send_item(func, row,
                      ($urandom_range(1) == 0) ? 10'($urandom_range(47)) : 10'($urandom),
                      random_value());
        end
    endtask

    initial begin
        error_count   = 0;
        idle_cycles   = 0;
        send_gap_pct  = 0;
        entry_count   = 16'd0;
        for (int r = 0; r < NROWS; r++) row_len[r] = 0;
        start         = 1'b0;
        i_func        = srlm_pkg::FN_READ;
        i_row_index   = 10'd0;
        i_col_index   = 10'd0;
        i_entry_value = 64'sd0;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_gap_pct = 0;
        test_random(450);
        send_gap_pct = 68;
        test_random(450);
        drain_results();
        send_gap_pct = 0;
        test_random(450);
        send_gap_pct = 37;
        test_random(450);

        drain_results();
        repeat (3 * SLOTS + 10) @(posedge i_clk);
        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("[sparse_row_list_matrix_store] OK");
        end else begin
            $display("[sparse_row_list_matrix_store] ERROR");
        end
        $finish;
    end
endmodule
